@@ hw/rtl/assert_macros.svh @@
// Assertion macros of the knapsack block, included by its top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/kmps_pkg.sv @@
// Shared widths, payload types and sweep control types of the knapsack block.
package kmps_pkg;

  localparam int BUDGET_W   = 10;
  localparam int ID_W       = 16;
  localparam int PROFIT_W   = 16;
  localparam int WEIGHT_W   = 10;
  localparam int TOTAL_W    = 22;
  localparam int WEIGHT_MAX = (1 << WEIGHT_W) - 1;
  // profit row cell: reach bit over the profit
  localparam int CELL_W     = TOTAL_W + 1;
  localparam int ITEM_W     = ID_W + PROFIT_W + WEIGHT_W;

  typedef struct packed {
    logic [BUDGET_W-1:0] budget;
    logic [ID_W-1:0]     item_id;
    logic [PROFIT_W-1:0] item_profit;
    logic [WEIGHT_W-1:0] item_weight;
    logic                last_item;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]     sel_id;
    logic [PROFIT_W-1:0] sel_profit;
    logic [WEIGHT_W-1:0] sel_weight;
    logic [TOTAL_W-1:0]  total_profit;
    logic [WEIGHT_W-1:0] total_weight;
    logic                none_selected;
    logic                too_many;
    logic                last_result;
  } result_t;

  // one stored item
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PROFIT_W-1:0] profit;
    logic [WEIGHT_W-1:0] weight;
  } item_word_t;

  typedef enum logic {
    OP_CLEAR,
    OP_ITEM
  } sweep_op_t;

  typedef struct packed {
    logic                start;
    sweep_op_t           op;
    logic [WEIGHT_W-1:0] cap;
    logic [WEIGHT_W-1:0] weight;
    logic [PROFIT_W-1:0] profit;
  } sweep_req_t;

  typedef struct packed {
    logic                done;
    logic                take_we;
    logic [WEIGHT_W-1:0] take_addr;
    logic                take_bit;
    logic                best_valid;
    logic [TOTAL_W-1:0]  best_profit;
    logic [WEIGHT_W-1:0] best_weight;
  } sweep_rsp_t;

endpackage

@@ hw/rtl/kmps_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
interface kmps_stream_if #(parameter type T = logic);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/kmps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/kmps_sweep.sv @@
// Profit row sweep unit: one shared add/compare step per weight, plus the row clearing pass.
module kmps_sweep #(
  parameter int CAP = 1023
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kmps_pkg::sweep_req_t req,
  output kmps_pkg::sweep_rsp_t rsp
);

  localparam int AW = $clog2(CAP + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                            state;
  kmps_pkg::sweep_op_t               op;
  logic [AW-1:0]                     cnt;
  logic [kmps_pkg::WEIGHT_W-1:0]     wt;
  logic [kmps_pkg::PROFIT_W-1:0]     pr;

  // stage A: compare and write on the read data, stage B: row best update, then the row best register
  logic                              a_valid;
  logic [AW-1:0]                     a_x;
  logic                              a_src_ok;
  logic                              b_valid;
  logic                              b_take;
  logic [kmps_pkg::TOTAL_W-1:0]      b_cand;
  logic [AW-1:0]                     b_x;
  logic                              rb_valid;
  logic [kmps_pkg::TOTAL_W-1:0]      rb_profit;
  logic [AW-1:0]                     rb_x;

  logic [kmps_pkg::WEIGHT_W-1:0]     cnt_w;
  logic                              src_ok;
  logic [AW-1:0]                     src_addr;
  logic [kmps_pkg::CELL_W-1:0]       tgt_rd;
  logic [kmps_pkg::CELL_W-1:0]       src_rd;
  logic                              tgt_reach;
  logic                              src_reach;
  logic [kmps_pkg::TOTAL_W-1:0]      tgt_profit;
  logic [kmps_pkg::TOTAL_W-1:0]      src_profit;
  logic [kmps_pkg::TOTAL_W-1:0]      cand;
  logic                              take;
  logic                              clearing;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic [kmps_pkg::CELL_W-1:0]       wdata;
  logic                              done;

  // source cell of the target under the counter
  assign cnt_w    = kmps_pkg::WEIGHT_W'(cnt);
  assign src_ok   = cnt_w >= wt;
  assign src_addr = AW'(cnt_w - wt);

  assign tgt_reach  = tgt_rd[kmps_pkg::CELL_W-1];
  assign tgt_profit = tgt_rd[kmps_pkg::TOTAL_W-1:0];
  assign src_reach  = src_rd[kmps_pkg::CELL_W-1];
  assign src_profit = src_rd[kmps_pkg::TOTAL_W-1:0];

  // shared add/compare: take the item where the cell is first reached or strictly improved
  assign cand = src_profit + kmps_pkg::TOTAL_W'(pr);
  assign take = a_src_ok && src_reach && (!tgt_reach || (cand > tgt_profit));

  // write port: clearing pass or improved cell
  assign clearing = (state == S_RUN) && (op == kmps_pkg::OP_CLEAR);
  assign we       = clearing || (a_valid && take);
  assign waddr    = clearing ? cnt : a_x;
  assign wdata    = clearing ? {(cnt == '0), {kmps_pkg::TOTAL_W{1'b0}}} : {1'b1, cand};

  assign done = (state == S_DRAIN) && !a_valid && !b_valid;

  // two copies of the row give the target and source reads in the same cycle
  kmps_ram #(
    .WIDTH (kmps_pkg::CELL_W),
    .DEPTH (CAP + 1)
  ) u_row_tgt (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (tgt_rd)
  );

  kmps_ram #(
    .WIDTH (kmps_pkg::CELL_W),
    .DEPTH (CAP + 1)
  ) u_row_src (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (src_addr),
    .rdata (src_rd)
  );

  // sequencer, pipeline stages and row best
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      rb_valid <= 1'b0;
    end else begin
      a_valid  <= (state == S_RUN) && (op == kmps_pkg::OP_ITEM);
      a_x      <= cnt;
      a_src_ok <= src_ok;
      b_valid  <= a_valid;
      b_take   <= take;
      b_cand   <= cand;
      b_x      <= a_x;
      // descending sweep: ties move the best to the lower weight
      if (b_valid && b_take && (!rb_valid || (b_cand >= rb_profit))) begin
        rb_valid  <= 1'b1;
        rb_profit <= b_cand;
        rb_x      <= b_x;
      end
      case (state)
        S_IDLE: begin
          if (req.start) begin
            op       <= req.op;
            wt       <= req.weight;
            pr       <= req.profit;
            cnt      <= (req.op == kmps_pkg::OP_CLEAR) ? AW'(CAP) : AW'(req.cap);
            rb_valid <= 1'b0;
            state    <= S_RUN;
          end
        end
        S_RUN: begin
          if (cnt == '0) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt - AW'(1);
          end
        end
        S_DRAIN: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done        = done;
  assign rsp.take_we     = a_valid;
  assign rsp.take_addr   = kmps_pkg::WEIGHT_W'(a_x);
  assign rsp.take_bit    = take;
  assign rsp.best_valid  = rb_valid;
  assign rsp.best_profit = rb_profit;
  assign rsp.best_weight = kmps_pkg::WEIGHT_W'(rb_x);

endmodule

@@ hw/rtl/knapsack_max_profit_select.sv @@
// knapsack_max_profit_select: exact-weight 0/1 knapsack DP with traceback of the chosen items.
// An absorbed item sweeps the profit row from cap down to weight 0 (cap = min(budget, MAX_BUDGET)):
// one weight per cycle through one add/compare unit; a dropped extra item is not swept.
// The answer starts from the best cell, then for each result reads and latches its item and probes
// the rows below for the next taken item; each result holds in the output register until transfer.
// Reset (rst, synchronous) and each job end clear the row over weights 0 to min(MAX_BUDGET, 1023).
`include "assert_macros.svh"

module knapsack_max_profit_select #(
  parameter int MAX_ITEMS  = 64,
  parameter int MAX_BUDGET = 1023
) (
  input logic          clk,
  input logic          rst,
  kmps_stream_if.sink   items,
  kmps_stream_if.source results
);

  localparam int CAP = (MAX_BUDGET > kmps_pkg::WEIGHT_MAX) ? kmps_pkg::WEIGHT_MAX : MAX_BUDGET;
  localparam int AW  = $clog2(CAP + 1);
  localparam int RW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int TAKE_DEPTH = 1 << (RW + AW);

  typedef enum logic [3:0] {
    S_CLEAR_GO,
    S_CLEAR_WAIT,
    S_IDLE,
    S_SWEEP_GO,
    S_SWEEP_WAIT,
    S_COMMIT,
    S_TRACE,
    S_ITEM_RD,
    S_ITEM_LATCH,
    S_PROBE,
    S_PROBE_CHK,
    S_OUT
  } state_t;

  state_t                         state;
  logic [CW-1:0]                  count;
  logic [AW-1:0]                  job_budget;
  logic [CW-1:0]                  best_row;
  logic [AW-1:0]                  best_weight;
  logic [kmps_pkg::TOTAL_W-1:0]   best_profit;
  logic                           overflow;
  logic                           fin;
  logic [kmps_pkg::WEIGHT_W-1:0]  cur_weight;
  logic [kmps_pkg::PROFIT_W-1:0]  cur_profit;
  logic [CW-1:0]                  tx;
  logic [AW-1:0]                  ty;
  logic                           out_valid;
  kmps_pkg::result_t              out_data;

  kmps_pkg::item_t                in_item;
  logic                           accept;
  logic                           has_room;
  logic [AW-1:0]                  bud_sat;
  logic [CW-1:0]                  tx_dec;
  kmps_pkg::item_word_t           item_wr;
  kmps_pkg::item_word_t           item_rd;
  logic                           item_we;
  logic                           take_rd;
  logic [kmps_pkg::WEIGHT_W-1:0]  ty_w;
  kmps_pkg::sweep_req_t           sweep_req;
  kmps_pkg::sweep_rsp_t           sweep_rsp;

  assign in_item      = items.data;
  assign items.ready  = (state == S_IDLE);
  assign accept       = items.valid && items.ready;
  assign has_room     = count < CW'(MAX_ITEMS);
  assign bud_sat      = (in_item.budget > kmps_pkg::BUDGET_W'(CAP)) ? AW'(CAP)
                                                                     : AW'(in_item.budget);
  assign tx_dec       = tx - CW'(1);
  assign ty_w         = kmps_pkg::WEIGHT_W'(ty);

  // store the item on transfer while rows remain
  assign item_we        = accept && has_room;
  assign item_wr.id     = in_item.item_id;
  assign item_wr.profit = in_item.item_profit;
  assign item_wr.weight = in_item.item_weight;

  kmps_ram #(
    .WIDTH (kmps_pkg::ITEM_W),
    .DEPTH (MAX_ITEMS)
  ) u_item_store (
    .clk   (clk),
    .we    (item_we),
    .waddr (count[RW-1:0]),
    .wdata (item_wr),
    .raddr (tx_dec[RW-1:0]),
    .rdata (item_rd)
  );

  // take bits: one row per item, written cell by cell during its sweep
  kmps_ram #(
    .WIDTH (1),
    .DEPTH (TAKE_DEPTH)
  ) u_take_bits (
    .clk   (clk),
    .we    (sweep_rsp.take_we),
    .waddr ({count[RW-1:0], AW'(sweep_rsp.take_addr)}),
    .wdata (sweep_rsp.take_bit),
    .raddr ({tx_dec[RW-1:0], ty}),
    .rdata (take_rd)
  );

  // sweep requests: clearing pass or one item row update
  assign sweep_req.start  = (state == S_SWEEP_GO) || (state == S_CLEAR_GO);
  assign sweep_req.op     = (state == S_CLEAR_GO) ? kmps_pkg::OP_CLEAR : kmps_pkg::OP_ITEM;
  assign sweep_req.cap    = kmps_pkg::WEIGHT_W'(job_budget);
  assign sweep_req.weight = cur_weight;
  assign sweep_req.profit = cur_profit;

  kmps_sweep #(
    .CAP (CAP)
  ) u_sweep (
    .clk (clk),
    .rst (rst),
    .req (sweep_req),
    .rsp (sweep_rsp)
  );

  // job sequencer and traceback; result held in the output register until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR_GO;
      count       <= '0;
      job_budget  <= '0;
      best_row    <= '0;
      best_weight <= '0;
      best_profit <= '0;
      overflow    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR_GO: begin
          state <= S_CLEAR_WAIT;
        end
        S_CLEAR_WAIT: begin
          if (sweep_rsp.done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_weight <= in_item.item_weight;
            cur_profit <= in_item.item_profit;
            fin        <= in_item.last_item;
            if (count == '0) begin
              job_budget <= bud_sat;
            end
            if (has_room) begin
              state <= S_SWEEP_GO;
            end else begin
              // drop the extra item
              overflow <= 1'b1;
              if (in_item.last_item) begin
                state <= S_TRACE;
              end
            end
          end
        end
        S_SWEEP_GO: begin
          state <= S_SWEEP_WAIT;
        end
        S_SWEEP_WAIT: begin
          if (sweep_rsp.done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          // earlier rows keep ties
          if (sweep_rsp.best_valid && (sweep_rsp.best_profit > best_profit)) begin
            best_row    <= count + CW'(1);
            best_weight <= AW'(sweep_rsp.best_weight);
            best_profit <= sweep_rsp.best_profit;
          end
          count <= count + CW'(1);
          state <= fin ? S_TRACE : S_IDLE;
        end
        S_TRACE: begin
          out_data.total_profit <= best_profit;
          out_data.total_weight <= kmps_pkg::WEIGHT_W'(best_weight);
          out_data.too_many     <= overflow;
          if (best_row == '0) begin
            out_data.sel_id        <= '0;
            out_data.sel_profit    <= '0;
            out_data.sel_weight    <= '0;
            out_data.none_selected <= 1'b1;
            out_data.last_result   <= 1'b1;
            out_valid              <= 1'b1;
            tx                     <= '0;
            state                  <= S_OUT;
          end else begin
            out_data.none_selected <= 1'b0;
            tx                     <= best_row;
            ty                     <= best_weight;
            state                  <= S_ITEM_RD;
          end
        end
        S_ITEM_RD: begin
          state <= S_ITEM_LATCH;
        end
        S_ITEM_LATCH: begin
          out_data.sel_id     <= item_rd.id;
          out_data.sel_profit <= item_rd.profit;
          out_data.sel_weight <= item_rd.weight;
          ty    <= (item_rd.weight > ty_w) ? '0 : AW'(ty_w - item_rd.weight);
          tx    <= tx_dec;
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (tx == '0) begin
            out_data.last_result <= 1'b1;
            out_valid            <= 1'b1;
            state                <= S_OUT;
          end else begin
            state <= S_PROBE_CHK;
          end
        end
        S_PROBE_CHK: begin
          // skip rows that did not take their item at this weight
          if (take_rd) begin
            out_data.last_result <= 1'b0;
            out_valid            <= 1'b1;
            state                <= S_OUT;
          end else begin
            tx    <= tx_dec;
            state <= S_PROBE;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (out_data.last_result) begin
              // return job state to reset values and clear the row
              count       <= '0;
              job_budget  <= '0;
              best_row    <= '0;
              best_weight <= '0;
              best_profit <= '0;
              overflow    <= 1'b0;
              state       <= S_CLEAR_GO;
            end else begin
              state <= S_ITEM_RD;
            end
          end
        end
        default: begin
          state <= S_CLEAR_GO;
        end
      endcase
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // no item taken while a result waits
  `ASSERT_IMPLIES(a_busy_while_result, clk, rst, out_valid, !items.ready)
  // best cell always lies in an absorbed row
  `ASSERT_ALWAYS(a_best_row_absorbed, clk, rst, (best_row <= count) && (count <= CW'(MAX_ITEMS)))
  // an empty answer is a single result
  `ASSERT_IMPLIES(a_empty_is_last, clk, rst, out_valid && out_data.none_selected, out_data.last_result)
  // the final transfer returns the job state to reset values
  `ASSERT_NEXT(a_job_cleared, clk, rst, out_valid && results.ready && out_data.last_result, (count == '0) && !overflow && (state == S_CLEAR_GO))

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the knapsack_max_profit_select block.
module tb;

  localparam int ITEM_CAP    = 64;
  localparam int BUDGET_CAP  = 1023;
  localparam int MAX_IDLE    = 8;
  localparam int STALL_LIMIT = 10000;
  localparam int DRAIN_TAIL  = 1100;

  // one queued item, with a flag that holds it until every selection has come back
  typedef struct packed {
    logic            drain_first;
    kmps_pkg::item_t it;
  } stim_t;

  logic clk;
  logic rst;

  kmps_stream_if #(.T(kmps_pkg::item_t))   items_ch ();
  kmps_stream_if #(.T(kmps_pkg::result_t)) results_ch ();

  knapsack_max_profit_select #(
    .MAX_ITEMS  (ITEM_CAP),
    .MAX_BUDGET (BUDGET_CAP)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // DP state of the job in progress
  logic [kmps_pkg::TOTAL_W-1:0] gain_at  [0:BUDGET_CAP];
  bit                           reach_at [0:BUDGET_CAP];
  bit                           taken_at [0:ITEM_CAP-1][0:BUDGET_CAP];
  kmps_pkg::item_word_t         held     [0:ITEM_CAP-1];
  int                           n_held;
  int                           job_cap;
  int                           best_row;
  int                           best_wt;
  logic [kmps_pkg::TOTAL_W-1:0] best_gain;
  bit                           dropped_any;

  stim_t             pending[$];
  kmps_pkg::result_t picks_due[$];

  int err_cnt     = 0;
  int n_queued    = 0;
  int n_items     = 0;
  int n_picks     = 0;
  int n_jobs      = 0;
  int n_empty     = 0;
  int n_overflow  = 0;
  int tx_gap      = 0;
  int rx_wait     = 0;
  int idle_cycles = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;

  logic item_xfer;
  logic result_xfer;
  assign item_xfer   = items_ch.valid && items_ch.ready;
  assign result_xfer = results_ch.valid && results_ch.ready;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Return the job state to its idle values: only weight zero reachable
  function automatic void reset_job_state();
    int w;
    for (w = 0; w <= BUDGET_CAP; w++) begin
      gain_at[w]  = '0;
      reach_at[w] = 1'b0;
    end
    reach_at[0] = 1'b1;
    n_held      = 0;
    job_cap     = 0;
    best_row    = 0;
    best_wt     = 0;
    best_gain   = '0;
    dropped_any = 1'b0;
  endfunction

  // Trace back from the best cell and queue the chosen items, last row first
  function automatic void emit_selection();
    kmps_pkg::result_t pick;
    int                row;
    int                wt;
    int                k;
    row = best_row;
    wt  = best_wt;
    k   = 0;
    while (row > 0 && k < ITEM_CAP) begin
      pick              = '0;
      pick.sel_id       = held[row-1].id;
      pick.sel_profit   = held[row-1].profit;
      pick.sel_weight   = held[row-1].weight;
      pick.total_profit = best_gain;
      pick.total_weight = kmps_pkg::WEIGHT_W'(best_wt);
      pick.too_many     = dropped_any;
      wt = (int'(held[row-1].weight) > wt) ? 0 : wt - int'(held[row-1].weight);
      row--;
      while (row > 0 && !taken_at[row-1][wt]) row--;
      k++;
      pick.last_result = (row == 0 || k == ITEM_CAP);
      picks_due = {picks_due, pick};
    end
    // empty subset: one result that says so
    if (k == 0) begin
      pick               = '0;
      pick.none_selected = 1'b1;
      pick.too_many      = dropped_any;
      pick.last_result   = 1'b1;
      picks_due = {picks_due, pick};
      n_empty++;
    end
    n_jobs++;
    if (dropped_any) n_overflow++;
    reset_job_state();
  endfunction

  // Fold one accepted item into the exact-weight profit row
  function automatic void absorb_item(input kmps_pkg::item_t it);
    int                           w;
    int                           dst;
    logic [kmps_pkg::TOTAL_W-1:0] cand;
    if (n_held == 0) job_cap = (int'(it.budget) > BUDGET_CAP) ? BUDGET_CAP : int'(it.budget);
    if (n_held < ITEM_CAP) begin
      held[n_held] = {it.item_id, it.item_profit, it.item_weight};
      for (w = 0; w <= job_cap; w++) taken_at[n_held][w] = 1'b0;
      // sweep high to low so every source cell is read before this item can write it
      for (w = job_cap; w >= 0; w--) begin
        dst = w + int'(it.item_weight);
        if (reach_at[w] && dst <= job_cap) begin
          cand = gain_at[w] + kmps_pkg::TOTAL_W'(it.item_profit);
          if (!reach_at[dst] || cand > gain_at[dst]) begin
            gain_at[dst]          = cand;
            reach_at[dst]         = 1'b1;
            taken_at[n_held][dst] = 1'b1;
          end
        end
      end
      // advance the best cell only on strictly higher profit
      for (w = 0; w <= job_cap; w++) begin
        if (taken_at[n_held][w] && gain_at[w] > best_gain) begin
          best_gain = gain_at[w];
          best_row  = n_held + 1;
          best_wt   = w;
        end
      end
      n_held++;
    end else begin
      dropped_any = 1'b1;
    end
    if (it.last_item) emit_selection();
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("%0t: selection %0d: %s is 0x%0h, expected 0x%0h",
             $time, n_picks, field, got, want);
  endtask

  task automatic check_pick(input kmps_pkg::result_t got, input kmps_pkg::result_t want);
    if (got.sel_id !== want.sel_id)
      report_mismatch("sel_id", 32'(got.sel_id), 32'(want.sel_id));
    if (got.sel_profit !== want.sel_profit)
      report_mismatch("sel_profit", 32'(got.sel_profit), 32'(want.sel_profit));
    if (got.sel_weight !== want.sel_weight)
      report_mismatch("sel_weight", 32'(got.sel_weight), 32'(want.sel_weight));
    if (got.total_profit !== want.total_profit)
      report_mismatch("total_profit", 32'(got.total_profit), 32'(want.total_profit));
    if (got.total_weight !== want.total_weight)
      report_mismatch("total_weight", 32'(got.total_weight), 32'(want.total_weight));
    if (got.none_selected !== want.none_selected)
      report_mismatch("none_selected", 32'(got.none_selected), 32'(want.none_selected));
    if (got.too_many !== want.too_many)
      report_mismatch("too_many", 32'(got.too_many), 32'(want.too_many));
    if (got.last_result !== want.last_result)
      report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
  endtask

  task automatic add_item(input int unsigned bud, input int unsigned id,
                          input int unsigned gain, input int unsigned wt,
                          input bit fin, input bit hold);
    stim_t s;
    s.drain_first    = hold;
    s.it.budget      = kmps_pkg::BUDGET_W'(bud);
    s.it.item_id     = kmps_pkg::ID_W'(id);
    s.it.item_profit = kmps_pkg::PROFIT_W'(gain);
    s.it.item_weight = kmps_pkg::WEIGHT_W'(wt);
    s.it.last_item   = fin;
    pending = {pending, s};
    n_queued++;
  endtask

  // Queue one job with random content; the first two jobs force the big cases
  task automatic add_random_job(input int job);
    int          kind;
    int          n;
    int          i;
    int unsigned bud;
    int unsigned wmax;
    int unsigned pmax;
    int unsigned wt;
    bit          hold;
    kind = (job < 2) ? job : $urandom_range(0, 29);
    hold = ($urandom_range(0, 5) == 0);
    case (kind)
      0: begin
        // light items: up to a full burst of selections
        n    = ITEM_CAP;
        bud  = $urandom_range(0, 64);
        wmax = 1;
        pmax = 65535;
      end
      1: begin
        // more items than the block holds; the final ones are dropped
        n    = $urandom_range(ITEM_CAP + 1, ITEM_CAP + 4);
        bud  = $urandom_range(0, 40);
        wmax = 12;
        pmax = 65535;
      end
      2: begin
        // wide budget, few items
        n    = $urandom_range(1, 4);
        bud  = ($urandom_range(0, 1) != 0) ? BUDGET_CAP : $urandom_range(512, 1023);
        wmax = 1023;
        pmax = 65535;
      end
      default: begin
        n    = $urandom_range(1, 10);
        bud  = $urandom_range(0, 48);
        wmax = bud + 4;
        pmax = (kind % 3 == 0) ? 15 : 65535;
      end
    endcase
    for (i = 0; i < n; i++) begin
      wt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, wmax);
      add_item((i == 0) ? bud : $urandom_range(0, 1023), $urandom_range(0, 65535),
               $urandom_range(0, pmax), wt, i == n - 1, hold && i == 0);
    end
  endtask

  // Item driver: hold each item until the transfer, then idle for a random gap, possibly none, before the next
  always @(posedge clk) begin : feeder
    stim_t head;
    if (rst) begin
      items_ch.valid <= 1'b0;
      items_ch.data  <= '0;
      tx_gap = 0;
    end else begin
      if (item_xfer) begin
        absorb_item(items_ch.data);
        n_items++;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      end
      if (!items_ch.valid || item_xfer) begin
        if (tx_gap > 0) begin
          items_ch.valid <= 1'b0;
          tx_gap--;
        end else if (pending.size() > 0 && !(pending[0].drain_first && picks_due.size() > 0)) begin
          head = pending.pop_front();
          items_ch.valid <= 1'b1;
          items_ch.data  <= head.it;
          tx_gap = idle_draw(tx_calm);
        end else begin
          items_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest pending selection
  always @(posedge clk) begin : result_mon
    kmps_pkg::result_t want;
    if (rst) begin
      results_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (result_xfer) begin
        n_picks++;
        if (picks_due.size() == 0) begin
          report_mismatch("result with no selection pending, sel_id",
                          32'(results_ch.data.sel_id), 32'd0);
        end else begin
          want = picks_due.pop_front();
          check_pick(results_ch.data, want);
        end
        rx_wait = idle_draw(rx_calm);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      end else if (results_ch.valid && rx_wait > 0) begin
        rx_wait--;
      end
      results_ch.ready <= (rx_wait == 0);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin : watchdog
    if (rst || item_xfer || result_xfer) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d selections outstanding",
               $time, STALL_LIMIT, picks_due.size());
      $display("knapsack_max_profit_select test failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    int job;
    int n_directed;
    rst              = 1'b1;
    items_ch.valid   = 1'b0;
    items_ch.data    = '0;
    results_ch.ready = 1'b0;
    reset_job_state();

    // zero budget, weightless item of top profit and id
    add_item(0, 16'hFFFF, 16'hFFFF, 0, 1'b1, 1'b0);
    // item heavier than the budget: empty answer
    add_item(5, 0, 9, 9, 1'b1, 1'b0);
    // top budget with top weights and a weightless zero-profit item
    add_item(BUDGET_CAP, 1, 16'hFFFF, 1023, 1'b0, 1'b0);
    add_item(0, 2, 0, 0, 1'b0, 1'b0);
    add_item(0, 3, 1, 1023, 1'b1, 1'b0);
    // zero profits only: empty answer
    add_item(10, 4, 0, 1, 1'b0, 1'b0);
    add_item(10, 5, 0, 2, 1'b0, 1'b0);
    add_item(10, 6, 0, 3, 1'b1, 1'b0);
    // equal profits: the earlier row keeps the best cell; wait for a drained block first
    add_item(8, 7, 10, 4, 1'b0, 1'b1);
    add_item(8, 8, 10, 4, 1'b0, 1'b0);
    add_item(8, 9, 20, 8, 1'b1, 1'b0);
    // budget on a later item is ignored
    add_item(3, 10, 5, 2, 1'b0, 1'b0);
    add_item(1023, 11, 50, 5, 1'b1, 1'b0);
    // two items that fill the top budget exactly
    add_item(BUDGET_CAP, 12, 100, 512, 1'b0, 1'b0);
    add_item(0, 13, 100, 511, 1'b0, 1'b0);
    add_item(0, 14, 150, 1023, 1'b1, 1'b0);
    // later items improve earlier cells
    add_item(6, 15, 3, 2, 1'b0, 1'b0);
    add_item(6, 16, 4, 2, 1'b0, 1'b0);
    add_item(6, 17, 5, 3, 1'b0, 1'b0);
    add_item(6, 18, 7, 4, 1'b1, 1'b0);

    n_directed = n_queued;
    job = 0;
    while (n_queued < n_directed + 410) begin
      add_random_job(job);
      job++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for all items and selections, then let the clearing pass run out
    @(negedge clk);
    while (pending.size() > 0 || items_ch.valid || picks_due.size() > 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Covered %0d jobs from %0d accepted items, %0d selections checked, %0d mismatches.",
             n_jobs, n_items, n_picks, err_cnt);
    $display("Jobs with an empty answer: %0d, jobs with dropped extra items: %0d.",
             n_empty, n_overflow);
    if (err_cnt == 0) begin
      $display("knapsack_max_profit_select test passed");
    end else begin
      $display("knapsack_max_profit_select test failed");
    end
    $finish;
  end

endmodule
